/* sv/dfr_pkg.sv */
package dfr_pkg;

    // table geometry
    localparam int MAX_ROWS = 4096;
    localparam int IDX_W    = $clog2(MAX_ROWS);
    localparam int ROW_W    = IDX_W + 1;

    // field widths
    localparam int REQ_W    = 3;
    localparam int ID_W     = 32;
    localparam int STATUS_W = 3;
    localparam int CNT_W    = 13;
    localparam int LIMIT_W  = 16;
    localparam int REQCNT_W = 17;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [REQCNT_W-1:0] COUNT_MAX = {REQCNT_W{1'b1}};

    // request codes
    localparam logic [REQ_W-1:0] REQ_RETAIN  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_FINISH  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_REWRITE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_READ    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR   = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE        = 3'd1;
    localparam logic [STATUS_W-1:0] ST_LIMIT        = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_RETAINED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FINISHED = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NULL_ENABLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NULL_VALUE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_LIMIT = 2'd3;

    // row memory access: presence bit on top of the dense index
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [ROW_W-1:0] wdata;
        logic [IDX_W-1:0] raddr;
    } row_req_t;

    // inverse list access
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [IDX_W-1:0] wdata;
        logic [IDX_W-1:0] raddr;
    } inv_req_t;

endpackage

/* sv/dense_feature_id_remap_top.sv */
// dense feature id remapper: retain requests mark source ids in a presence map held in a
// row memory (one entry per source row: presence bit plus dense index), a finish request
// walks that memory in ascending order, ranks each marked row and fills the inverse list
// memory, after which rewrite requests return the dense id of a source id and read requests
// return the nth retained source id. every request gives exactly one result. after reset and
// after every clear request a clearing pass (one row a cycle) empties the presence map, during
// which no request is taken; configuration writes are taken at any time but belong to idle
// periods. retain, clear, unknown and early-rejected requests answer in the cycle after their
// transfer; rewrite and read pass through a lookup state for the registered read of the row
// memory or inverse list; finish answers once the single-row-per-cycle walk over the row
// memory is done. a new request is taken once the previous one is done and the result
// register is free or being emptied, so short requests stream at one a cycle.
module dense_feature_id_remap_top
    import dfr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // request channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [REQ_W-1:0]      s_req_type,
    input  logic [ID_W-1:0]       s_feature_id,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STATUS_W-1:0]   m_status,
    output logic [CNT_W-1:0]      m_mapped_id,
    output logic [CNT_W-1:0]      m_retained_total
);

    row_req_t         row_req;
    inv_req_t         inv_req;
    logic [ROW_W-1:0] row_rdata;
    logic [IDX_W-1:0] inv_rdata;

    // sequencer: request decode, finish walk, clearing pass and result register
    dfr_core u_core (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_feature_id     (s_feature_id),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_mapped_id      (m_mapped_id),
        .m_retained_total (m_retained_total),
        .row_req          (row_req),
        .row_rdata        (row_rdata),
        .inv_req          (inv_req),
        .inv_rdata        (inv_rdata)
    );

    // row memory: presence bit and dense index per source row
    dfr_ram #(
        .DEPTH (MAX_ROWS),
        .WIDTH (ROW_W)
    ) u_row_ram (
        .aclk  (aclk),
        .we    (row_req.we),
        .waddr (row_req.waddr),
        .wdata (row_req.wdata),
        .raddr (row_req.raddr),
        .rdata (row_rdata)
    );

    // inverse list: retained source id per dense index
    dfr_ram #(
        .DEPTH (MAX_ROWS),
        .WIDTH (IDX_W)
    ) u_inv_ram (
        .aclk  (aclk),
        .we    (inv_req.we),
        .waddr (inv_req.waddr),
        .wdata (inv_req.wdata),
        .raddr (inv_req.raddr),
        .rdata (inv_rdata)
    );

endmodule

/* sv/dfr_ram.sv */
module dfr_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 12
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

/* sv/dfr_core.sv */
module dfr_core
    import dfr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [REQ_W-1:0]      s_req_type,
    input  logic [ID_W-1:0]       s_feature_id,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STATUS_W-1:0]   m_status,
    output logic [CNT_W-1:0]      m_mapped_id,
    output logic [CNT_W-1:0]      m_retained_total,
    output row_req_t              row_req,
    input  logic [ROW_W-1:0]      row_rdata,
    output inv_req_t              inv_req,
    input  logic [IDX_W-1:0]      inv_rdata
);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_LOOKUP, S_WALK} state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]    rows_cfg_reg, rows_cfg_next;
    logic                null_en_reg, null_en_next;
    logic [ID_W-1:0]     null_val_reg, null_val_next;
    logic [LIMIT_W-1:0]  limit_reg, limit_next;

    logic [CNT_W-1:0]    kept_reg, kept_next;
    logic [REQCNT_W-1:0] req_cnt_reg, req_cnt_next;
    logic                fin_reg, fin_next;

    logic [IDX_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [CNT_W-1:0]    walk_cnt_reg, walk_cnt_next;
    logic                pend_vld_reg, pend_vld_next;
    logic [IDX_W-1:0]    pend_addr_reg, pend_addr_next;
    logic [CNT_W-1:0]    rank_reg, rank_next;
    logic                lookup_read_reg, lookup_read_next;

    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic [CNT_W-1:0]    m_mapped_reg, m_mapped_next;
    logic [CNT_W-1:0]    m_total_reg, m_total_next;

    logic                res_vld;
    logic [STATUS_W-1:0] res_status;
    logic [CNT_W-1:0]    res_mapped;
    logic                accept;
    logic                is_null;
    logic                oversize;

    assign s_ready  = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign accept   = s_valid && s_ready;
    assign is_null  = null_en_reg && (s_feature_id == null_val_reg);
    assign oversize = rows_cfg_reg > CNT_W'(MAX_ROWS);

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_mapped_id      = m_mapped_reg;
    assign m_retained_total = m_total_reg;

    always_comb begin
        state_next       = state_reg;
        rows_cfg_next    = rows_cfg_reg;
        null_en_next     = null_en_reg;
        null_val_next    = null_val_reg;
        limit_next       = limit_reg;
        kept_next        = kept_reg;
        req_cnt_next     = req_cnt_reg;
        fin_next         = fin_reg;
        clr_cnt_next     = clr_cnt_reg;
        walk_cnt_next    = walk_cnt_reg;
        pend_vld_next    = pend_vld_reg;
        pend_addr_next   = pend_addr_reg;
        rank_next        = rank_reg;
        lookup_read_next = lookup_read_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_status_next    = m_status_reg;
        m_mapped_next    = m_mapped_reg;
        m_total_next     = m_total_reg;
        res_vld          = 1'b0;
        res_status       = ST_OK;
        res_mapped       = '0;
        row_req          = '0;
        inv_req          = '0;

        if (cfg_we) begin
            case (cfg_index)
                CFG_ROW_COUNT:   rows_cfg_next = cfg_wdata[CNT_W-1:0];
                CFG_NULL_ENABLE: null_en_next  = cfg_wdata[0];
                CFG_NULL_VALUE:  null_val_next = cfg_wdata[ID_W-1:0];
                CFG_ENTRY_LIMIT: limit_next    = cfg_wdata[LIMIT_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            S_CLEAR: begin
                row_req.we    = 1'b1;
                row_req.waddr = clr_cnt_reg;
                row_req.wdata = '0;
                clr_cnt_next  = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == IDX_W'(MAX_ROWS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    case (s_req_type)
                        REQ_RETAIN: begin
                            if (req_cnt_reg != COUNT_MAX) begin
                                req_cnt_next = req_cnt_reg + 1'b1;
                            end
                            fin_next = 1'b0;
                            res_vld  = 1'b1;
                            if (req_cnt_reg >= REQCNT_W'(limit_reg) || oversize) begin
                                res_status = ST_LIMIT;
                            end else if (is_null) begin
                                res_status = ST_OK;
                            end else if (s_feature_id >= ID_W'(rows_cfg_reg)) begin
                                res_status = ST_RANGE;
                            end else begin
                                row_req.we    = 1'b1;
                                row_req.waddr = s_feature_id[IDX_W-1:0];
                                row_req.wdata = {1'b1, {IDX_W{1'b0}}};
                            end
                        end
                        REQ_FINISH: begin
                            if (oversize) begin
                                res_vld    = 1'b1;
                                res_status = ST_LIMIT;
                            end else begin
                                state_next    = S_WALK;
                                walk_cnt_next = '0;
                                pend_vld_next = 1'b0;
                                rank_next     = '0;
                            end
                        end
                        REQ_REWRITE: begin
                            if (!fin_reg) begin
                                res_vld    = 1'b1;
                                res_status = ST_NOT_FINISHED;
                            end else if (is_null) begin
                                res_vld    = 1'b1;
                                res_mapped = kept_reg;
                            end else if (s_feature_id >= ID_W'(MAX_ROWS)) begin
                                res_vld    = 1'b1;
                                res_status = ST_NOT_RETAINED;
                            end else begin
                                row_req.raddr    = s_feature_id[IDX_W-1:0];
                                lookup_read_next = 1'b0;
                                state_next       = S_LOOKUP;
                            end
                        end
                        REQ_READ: begin
                            if (!fin_reg) begin
                                res_vld    = 1'b1;
                                res_status = ST_NOT_FINISHED;
                            end else if (s_feature_id >= ID_W'(kept_reg)) begin
                                res_vld    = 1'b1;
                                res_status = ST_RANGE;
                            end else begin
                                inv_req.raddr    = s_feature_id[IDX_W-1:0];
                                lookup_read_next = 1'b1;
                                state_next       = S_LOOKUP;
                            end
                        end
                        REQ_CLEAR: begin
                            kept_next    = '0;
                            req_cnt_next = '0;
                            fin_next     = 1'b0;
                            clr_cnt_next = '0;
                            state_next   = S_CLEAR;
                            res_vld      = 1'b1;
                        end
                        default: begin
                            res_vld = 1'b1;
                        end
                    endcase
                end
            end
            S_LOOKUP: begin
                res_vld    = 1'b1;
                state_next = S_IDLE;
                if (lookup_read_reg) begin
                    res_mapped = CNT_W'(inv_rdata);
                end else if (row_rdata[ROW_W-1]) begin
                    res_mapped = CNT_W'(row_rdata[IDX_W-1:0]);
                end else begin
                    res_status = ST_NOT_RETAINED;
                end
            end
            S_WALK: begin
                // issue side: one row read per cycle
                if (walk_cnt_reg != CNT_W'(MAX_ROWS)) begin
                    row_req.raddr  = walk_cnt_reg[IDX_W-1:0];
                    pend_vld_next  = 1'b1;
                    pend_addr_next = walk_cnt_reg[IDX_W-1:0];
                    walk_cnt_next  = walk_cnt_reg + 1'b1;
                end else begin
                    pend_vld_next = 1'b0;
                end
                // return side: rank the row that came back
                if (pend_vld_reg) begin
                    if (CNT_W'(pend_addr_reg) >= rows_cfg_reg) begin
                        row_req.we    = 1'b1;
                        row_req.waddr = pend_addr_reg;
                        row_req.wdata = '0;
                    end else if (row_rdata[ROW_W-1]) begin
                        row_req.we    = 1'b1;
                        row_req.waddr = pend_addr_reg;
                        row_req.wdata = {1'b1, rank_reg[IDX_W-1:0]};
                        inv_req.we    = 1'b1;
                        inv_req.waddr = rank_reg[IDX_W-1:0];
                        inv_req.wdata = pend_addr_reg;
                        rank_next     = rank_reg + 1'b1;
                    end
                    if (pend_addr_reg == IDX_W'(MAX_ROWS - 1)) begin
                        kept_next  = rank_next;
                        fin_next   = 1'b1;
                        res_vld    = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (res_vld) begin
            m_valid_next  = 1'b1;
            m_status_next = res_status;
            m_mapped_next = res_mapped;
            m_total_next  = kept_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_CLEAR;
            rows_cfg_reg    <= '0;
            null_en_reg     <= 1'b0;
            null_val_reg    <= '0;
            limit_reg       <= {LIMIT_W{1'b1}};
            kept_reg        <= '0;
            req_cnt_reg     <= '0;
            fin_reg         <= 1'b0;
            clr_cnt_reg     <= '0;
            walk_cnt_reg    <= '0;
            pend_vld_reg    <= 1'b0;
            rank_reg        <= '0;
            lookup_read_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            rows_cfg_reg    <= rows_cfg_next;
            null_en_reg     <= null_en_next;
            null_val_reg    <= null_val_next;
            limit_reg       <= limit_next;
            kept_reg        <= kept_next;
            req_cnt_reg     <= req_cnt_next;
            fin_reg         <= fin_next;
            clr_cnt_reg     <= clr_cnt_next;
            walk_cnt_reg    <= walk_cnt_next;
            pend_vld_reg    <= pend_vld_next;
            rank_reg        <= rank_next;
            lookup_read_reg <= lookup_read_next;
            m_valid_reg     <= m_valid_next;
        end
        pend_addr_reg <= pend_addr_next;
        m_status_reg  <= m_status_next;
        m_mapped_reg  <= m_mapped_next;
        m_total_reg   <= m_total_next;
    end

endmodule
